>>> sv/hermite_spline_sampler_core_macros.svh
// Assertion macros for the Hermite spline sampler core.
`ifndef HERMITE_SPLINE_SAMPLER_CORE_MACROS_SVH
`define HERMITE_SPLINE_SAMPLER_CORE_MACROS_SVH

// Check that an antecedent implies a consequent on the next clock.
`define HSS_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

// Check that an antecedent implies a consequent in the same clock.
`define HSS_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

`endif

>>> sv/hss_pkg.sv
// Package: constants, types and helpers of the Hermite spline sampler.
`default_nettype none
package hss_pkg;
    localparam int COORD_BITS_DEF  = 32;
    localparam int MAX_SAMPLES_DEF = 25;
    localparam int STEP_BITS       = 16;
    localparam logic [STEP_BITS-1:0] STEP_RESET = 16'd3277;
    localparam logic [STEP_BITS-1:0] MIN_STEP   = 16'd2622;
    localparam int T_BITS          = 17;
    // basis values in units of 2^-48, magnitude up to 2^48
    localparam int H_BITS          = 52;

    // segment kinds the controller asks for
    typedef enum logic [1:0] {
        SEG_FIRST,   // p1 -> cur, straight (two point curve)
        SEG_MID,     // p2 -> p1
        SEG_LAST     // p1 -> cur, closing segment
    } seg_kind_t;

    // controller to datapath commands
    typedef struct packed {
        logic      load_point;  // latch the input item
        logic      seg_start;   // set up operands of a segment, t = 0
        seg_kind_t seg_kind;
        logic      k_is_two;    // inner tangent uses one-sided difference
        logic      sample_go;   // start computing one sample
        logic      commit;      // update the point window
        logic      clear_win;   // clear the window on the final point
        logic      emit_end;    // load the endpoint into the output register
    } hss_cmd_t;

    // datapath to controller status
    typedef struct packed {
        logic sample_done;  // a computed sample is loaded into the output register
        logic out_free;     // output register empty or being taken
        logic seg_last;     // current sample is the last of its segment
    } hss_stat_t;
endpackage
`default_nettype wire

>>> sv/hss_if.sv
// Valid/ready channel interfaces for points and samples.
`default_nettype none
interface hss_point_if #(parameter int COORD_BITS = 32);
    logic                         valid;
    logic                         ready;
    logic signed [COORD_BITS-1:0] point_x;
    logic signed [COORD_BITS-1:0] point_y;
    logic signed [COORD_BITS-1:0] point_z;
    logic                         final_point;
    modport source (output valid, point_x, point_y, point_z, final_point, input ready);
    modport sink (input valid, point_x, point_y, point_z, final_point, output ready);
endinterface

interface hss_sample_if #(parameter int COORD_BITS = 32);
    logic                         valid;
    logic                         ready;
    logic signed [COORD_BITS-1:0] out_x;
    logic signed [COORD_BITS-1:0] out_y;
    logic signed [COORD_BITS-1:0] out_z;
    logic                         run_end;
    logic                         curve_end;
    modport source (output valid, out_x, out_y, out_z, run_end, curve_end, input ready);
    modport sink (input valid, out_x, out_y, out_z, run_end, curve_end, output ready);
endinterface
`default_nettype wire

>>> sv/hss_datapath.sv
// Datapath: point window, basis generation, multiply-accumulate, output register.
`default_nettype none
module hss_datapath
    import hss_pkg::*;
#(
    parameter int COORD_BITS  = COORD_BITS_DEF,
    parameter int MAX_SAMPLES = MAX_SAMPLES_DEF
)
(
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic [STEP_BITS-1:0]         step_size,
    input  wire logic signed [COORD_BITS-1:0] in_x,
    input  wire logic signed [COORD_BITS-1:0] in_y,
    input  wire logic signed [COORD_BITS-1:0] in_z,
    input  wire hss_cmd_t                     cmd,
    input  wire logic                         run_end_in,
    input  wire logic                         out_ready,
    output hss_stat_t                         stat,
    output logic                              out_valid,
    output logic signed [COORD_BITS-1:0]      out_x,
    output logic signed [COORD_BITS-1:0]      out_y,
    output logic signed [COORD_BITS-1:0]      out_z,
    output logic                              out_run_end,
    output logic                              out_curve_end
);
    localparam int CB  = COORD_BITS;
    localparam int DB  = COORD_BITS + 2;           // doubled value or difference
    localparam int PB  = H_BITS + DB;              // one product
    localparam int AB  = PB + 2;                   // sum of four products
    localparam int SB  = AB - 49;                  // sum with the fraction bits dropped
    localparam int HL  = H_BITS / 2;               // low slice of a basis value
    localparam int HH  = H_BITS - HL;              // high slice of a basis value
    localparam int DL  = DB / 2;                   // low slice of an operand
    localparam int DH  = DB - DL;                  // high slice of an operand
    localparam int CNT_BITS = $clog2(MAX_SAMPLES + 1);

    typedef logic signed [CB-1:0] coord_t;
    typedef logic signed [DB-1:0] dbl_t;
    typedef logic signed [H_BITS-1:0] h_t;
    typedef logic signed [AB-1:0] acc_t;
    typedef logic signed [HH:0] hs_t;
    typedef logic signed [DH:0] ds_t;
    typedef logic signed [HH+DH+1:0] pprod_t;

    // point window: p3 oldest, p1 newest
    coord_t p1_reg [3];
    coord_t p2_reg [3];
    coord_t p3_reg [3];
    coord_t cur_reg [3];
    // segment operands: 2a, 2b and doubled tangents
    dbl_t a2_reg [3];
    dbl_t b2_reg [3];
    dbl_t da_reg [3];
    dbl_t db_reg [3];

    logic [STEP_BITS-1:0]  step_reg;
    logic [T_BITS-1:0]     t_reg;
    logic [CNT_BITS-1:0]   idx_reg;
    logic [CNT_BITS-1:0]   count_reg;
    logic [CNT_BITS-1:0]   count_next;

    // sample sequencer: phase 0 squares, 1 basis, then per axis phase 2
    // (four partial product steps and a trailing add) and phase 3 (round),
    // phase 4 hands the sample off
    logic [2:0]            phase_reg;
    logic [2:0]            sub_reg;
    logic                  busy_reg;
    logic [1:0]            axis_reg;
    h_t                    h_reg [4];
    acc_t                  pp_reg [4];
    acc_t                  acc_reg;
    coord_t                res_reg [3];

    logic                  ovalid_reg;
    coord_t                ox_reg, oy_reg, oz_reg;
    logic                  orun_reg, ocurve_reg;
    logic                  sample_done_w;

    // sample count: smallest n with n*step >= 65536, capped
    logic [STEP_BITS-1:0]  eff_step;
    always_comb
    begin
        eff_step = (step_size < MIN_STEP) ? MIN_STEP : step_size;
        count_next = CNT_BITS'(MAX_SAMPLES);
        for (int n = MAX_SAMPLES; n >= 1; n--)
        begin
            if ((32'(n) * 32'(eff_step)) >= 32'd65536)
            begin
                count_next = CNT_BITS'(n);
            end
        end
    end

    // basis functions in units of 2^-48 from t
    logic signed [T_BITS+1:0] t_s, u_s;
    logic signed [2*T_BITS+3:0] tt_w, uu_w, tu_w;
    always_comb
    begin
        t_s  = {2'b00, t_reg};
        u_s  = 19'sd65536 - t_s;
        tt_w = 38'(t_s * t_s);
        uu_w = 38'(u_s * u_s);
        tu_w = 38'(t_s * u_s);
    end
    logic signed [37:0] tt_reg, uu_reg, tu_reg;
    logic signed [T_BITS+1:0] tq_reg;

    // partial products: basis and operand split in halves, one pair per step
    dbl_t   op_w [4];
    hs_t    h_sel [4];
    ds_t    d_sel [4];
    pprod_t pprod_w [4];
    acc_t   pp_w [4];
    acc_t   sum_w;
    acc_t   rnd_w;
    logic signed [SB-1:0] shifted;
    coord_t sat_w;
    always_comb
    begin
        op_w[0] = a2_reg[axis_reg];
        op_w[1] = da_reg[axis_reg];
        op_w[2] = b2_reg[axis_reg];
        op_w[3] = db_reg[axis_reg];
        for (int k = 0; k < 4; k++)
        begin
            if (sub_reg[1])
                h_sel[k] = hs_t'($signed(h_reg[k][H_BITS-1:HL]));
            else
                h_sel[k] = hs_t'({1'b0, h_reg[k][HL-1:0]});
            if (sub_reg[0])
                d_sel[k] = ds_t'($signed(op_w[k][DB-1:DL]));
            else
                d_sel[k] = ds_t'({1'b0, op_w[k][DL-1:0]});
            pprod_w[k] = h_sel[k] * d_sel[k];
            case (sub_reg[1:0])
                2'd0:    pp_w[k] = AB'(pprod_w[k]);
                2'd1:    pp_w[k] = AB'(pprod_w[k]) <<< DL;
                2'd2:    pp_w[k] = AB'(pprod_w[k]) <<< HL;
                default: pp_w[k] = AB'(pprod_w[k]) <<< (HL + DL);
            endcase
        end
        sum_w = acc_reg + pp_reg[0] + pp_reg[1] + pp_reg[2] + pp_reg[3];
        // round to nearest, drop the fraction, saturate
        rnd_w = acc_reg + (AB'(1) <<< 48);
        shifted = rnd_w[AB-1:49];
        if (shifted > SB'((64'sd1 <<< (CB-1)) - 1))
            sat_w = {1'b0, {(CB-1){1'b1}}};
        else if (shifted < -SB'(64'sd1 <<< (CB-1)))
            sat_w = {1'b1, {(CB-1){1'b0}}};
        else
            sat_w = shifted[CB-1:0];
    end

    assign sample_done_w = busy_reg && (phase_reg == 3'd4) && (!ovalid_reg || out_ready);

    // sequence of one sample: squares, basis, per axis mul, sum, round, hand-off
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg   <= 1'b0;
            phase_reg  <= '0;
            sub_reg    <= '0;
            axis_reg   <= '0;
            acc_reg    <= '0;
            ovalid_reg <= 1'b0;
            for (int j = 0; j < 3; j++)
            begin
                p1_reg[j] <= '0;
                p2_reg[j] <= '0;
                p3_reg[j] <= '0;
            end
            step_reg  <= STEP_RESET;
            t_reg     <= '0;
            idx_reg   <= '0;
            count_reg <= '0;
        end
        else
        begin
            // raise valid on a new sample or endpoint, drop it once taken
            if (sample_done_w || cmd.emit_end)
            begin
                ovalid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                ovalid_reg <= 1'b0;
            end
            if (cmd.load_point)
            begin
                cur_reg[0] <= in_x;
                cur_reg[1] <= in_y;
                cur_reg[2] <= in_z;
            end
            if (cmd.seg_start)
            begin
                step_reg  <= eff_step;
                count_reg <= count_next;
                t_reg     <= '0;
                idx_reg   <= '0;
                for (int j = 0; j < 3; j++)
                begin
                    unique case (cmd.seg_kind)
                        SEG_FIRST:
                        begin
                            a2_reg[j] <= DB'(p1_reg[j]) <<< 1;
                            b2_reg[j] <= DB'(cur_reg[j]) <<< 1;
                            da_reg[j] <= DB'(cur_reg[j]) - DB'(p1_reg[j]);
                            db_reg[j] <= DB'(cur_reg[j]) - DB'(p1_reg[j]);
                        end
                        SEG_MID:
                        begin
                            a2_reg[j] <= DB'(p2_reg[j]) <<< 1;
                            b2_reg[j] <= DB'(p1_reg[j]) <<< 1;
                            da_reg[j] <= cmd.k_is_two ? DB'(p1_reg[j]) - DB'(p2_reg[j])
                                                      : DB'(p1_reg[j]) - DB'(p3_reg[j]);
                            db_reg[j] <= DB'(cur_reg[j]) - DB'(p2_reg[j]);
                        end
                        SEG_LAST:
                        begin
                            a2_reg[j] <= DB'(p1_reg[j]) <<< 1;
                            b2_reg[j] <= DB'(cur_reg[j]) <<< 1;
                            da_reg[j] <= DB'(cur_reg[j]) - DB'(p2_reg[j]);
                            db_reg[j] <= DB'(cur_reg[j]) - DB'(p1_reg[j]);
                        end
                        default:
                        begin
                            a2_reg[j] <= '0;
                            b2_reg[j] <= '0;
                            da_reg[j] <= '0;
                            db_reg[j] <= '0;
                        end
                    endcase
                end
            end
            if (cmd.sample_go)
            begin
                busy_reg  <= 1'b1;
                phase_reg <= '0;
                axis_reg  <= '0;
                sub_reg   <= '0;
                acc_reg   <= '0;
            end
            else if (busy_reg)
            begin
                case (phase_reg)
                    3'd0:
                    begin
                        tt_reg <= tt_w;
                        uu_reg <= uu_w;
                        tu_reg <= tu_w;
                        tq_reg <= t_s;
                        phase_reg <= 3'd1;
                    end
                    3'd1:
                    begin
                        h_reg[0] <= H_BITS'((19'sd65536 + (t_s <<< 1)) * uu_reg);
                        h_reg[1] <= H_BITS'(tq_reg * uu_reg);
                        h_reg[2] <= H_BITS'(tt_reg * (19'sd196608 - (t_s <<< 1)));
                        h_reg[3] <= H_BITS'(-(tu_reg * tq_reg));
                        phase_reg <= 3'd2;
                    end
                    3'd2:
                    begin
                        // capture one partial product step, add the previous one
                        if (sub_reg != 3'd4)
                        begin
                            for (int k = 0; k < 4; k++)
                            begin
                                pp_reg[k] <= pp_w[k];
                            end
                        end
                        if (sub_reg != 3'd0)
                        begin
                            acc_reg <= sum_w;
                        end
                        if (sub_reg == 3'd4)
                        begin
                            phase_reg <= 3'd3;
                        end
                        else
                        begin
                            sub_reg <= sub_reg + 3'd1;
                        end
                    end
                    3'd3:
                    begin
                        res_reg[axis_reg] <= sat_w;
                        acc_reg <= '0;
                        sub_reg <= '0;
                        if (axis_reg == 2'd2)
                        begin
                            phase_reg <= 3'd4;
                        end
                        else
                        begin
                            axis_reg  <= axis_reg + 2'd1;
                            phase_reg <= 3'd2;
                        end
                    end
                    default:
                    begin
                        // wait for the output register to free up
                        if (sample_done_w)
                        begin
                            ox_reg     <= res_reg[0];
                            oy_reg     <= res_reg[1];
                            oz_reg     <= res_reg[2];
                            orun_reg   <= run_end_in;
                            ocurve_reg <= 1'b0;
                            busy_reg   <= 1'b0;
                            t_reg      <= t_reg + T_BITS'(step_reg);
                            idx_reg    <= idx_reg + CNT_BITS'(1);
                        end
                    end
                endcase
            end
            if (cmd.emit_end)
            begin
                ox_reg     <= cur_reg[0];
                oy_reg     <= cur_reg[1];
                oz_reg     <= cur_reg[2];
                orun_reg   <= 1'b1;
                ocurve_reg <= 1'b1;
            end
            if (cmd.clear_win)
            begin
                for (int j = 0; j < 3; j++)
                begin
                    p1_reg[j] <= '0;
                    p2_reg[j] <= '0;
                    p3_reg[j] <= '0;
                end
            end
            else if (cmd.commit)
            begin
                for (int j = 0; j < 3; j++)
                begin
                    p3_reg[j] <= p2_reg[j];
                    p2_reg[j] <= p1_reg[j];
                    p1_reg[j] <= cur_reg[j];
                end
            end
        end
    end

    assign stat.sample_done = sample_done_w;
    assign stat.out_free    = !ovalid_reg || out_ready;
    assign stat.seg_last    = (idx_reg + CNT_BITS'(1)) >= count_reg;

    assign out_valid     = ovalid_reg;
    assign out_x         = ox_reg;
    assign out_y         = oy_reg;
    assign out_z         = oz_reg;
    assign out_run_end   = orun_reg;
    assign out_curve_end = ocurve_reg;
endmodule
`default_nettype wire

>>> sv/hss_ctrl.sv
// Controller: sequences segments and samples for each accepted point.
`default_nettype none
module hss_ctrl
    import hss_pkg::*;
(
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire logic      in_valid,
    input  wire logic      in_final,
    output logic           in_ready,
    input  hss_stat_t      stat,
    output hss_cmd_t       cmd,
    output logic           run_end
);
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DECIDE,
        ST_SETUP,
        ST_GO,
        ST_WAIT,
        ST_END
    } state_t;

    state_t     state_reg, state_next;
    logic [1:0] seen_reg, seen_next;
    logic       fin_reg, fin_next;
    seg_kind_t  kind_reg, kind_next;

    always_comb
    begin
        state_next = state_reg;
        seen_next  = seen_reg;
        fin_next   = fin_reg;
        kind_next  = kind_reg;
        cmd        = '0;
        cmd.seg_kind = kind_reg;
        cmd.k_is_two = (seen_reg == 2'd2);
        in_ready   = (state_reg == ST_IDLE);
        // last sample of this item: last segment and no closing endpoint
        run_end    = stat.seg_last && !fin_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load_point = 1'b1;
                    fin_next   = in_final;
                    state_next = ST_DECIDE;
                end
            end
            ST_DECIDE:
            begin
                if (fin_reg && seen_reg == 2'd1)
                begin
                    kind_next  = SEG_FIRST;
                    state_next = ST_SETUP;
                end
                else if (seen_reg >= 2'd2)
                begin
                    kind_next  = SEG_MID;
                    state_next = ST_SETUP;
                end
                else
                begin
                    state_next = ST_END;
                end
            end
            ST_SETUP:
            begin
                cmd.seg_start = 1'b1;
                state_next = ST_GO;
            end
            ST_GO:
            begin
                cmd.sample_go = 1'b1;
                state_next = ST_WAIT;
            end
            ST_WAIT:
            begin
                if (stat.sample_done)
                begin
                    if (!stat.seg_last)
                        state_next = ST_GO;
                    else if (fin_reg && kind_reg == SEG_MID)
                    begin
                        kind_next  = SEG_LAST;
                        state_next = ST_SETUP;
                    end
                    else
                        state_next = ST_END;
                end
            end
            ST_END:
            begin
                if (fin_reg)
                begin
                    if (stat.out_free)
                    begin
                        cmd.emit_end  = 1'b1;
                        cmd.clear_win = 1'b1;
                        seen_next  = 2'd0;
                        state_next = ST_IDLE;
                    end
                end
                else
                begin
                    cmd.commit = 1'b1;
                    seen_next  = (seen_reg == 2'd3) ? 2'd3 : seen_reg + 2'd1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            seen_reg  <= 2'd0;
            fin_reg   <= 1'b0;
            kind_reg  <= SEG_MID;
        end
        else
        begin
            state_reg <= state_next;
            seen_reg  <= seen_next;
            fin_reg   <= fin_next;
            kind_reg  <= kind_next;
        end
    end
endmodule
`default_nettype wire

>>> sv/hermite_spline_sampler_core.sv
// Top level: Hermite spline sampler with controller and datapath.
// Usage:
//  - point_in (sink): control points with a final_point flag; one transaction
//    per point. The block takes one point at a time.
//  - sample_out (source): curve samples; run_end marks the last sample caused
//    by a point, curve_end marks the closing endpoint of the curve.
//  - step_we/step_wdata: write the Q0.16 step, only while the block is idle.
// Sequencing: each segment has a setup step, then each sample runs a start,
//  the squares of t, the basis, per axis the partial product steps, a final
//  add and a round, then the hand-off of the sample. A closing endpoint is
//  loaded after the last segment. The default step gives 20 samples per
//  segment.
// Reset clears the point window, the point count and the output valid flag, and
//  sets the step to 3277.
// When the receiver stalls, the finished sample waits in the output register
//  and the next sample is computed behind it, then held until it is taken.
`default_nettype none
`include "hermite_spline_sampler_core_macros.svh"
module hermite_spline_sampler_core
    import hss_pkg::*;
#(
    parameter int COORD_BITS  = COORD_BITS_DEF,
    parameter int MAX_SAMPLES = MAX_SAMPLES_DEF
)
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 step_we,
    input  wire logic [STEP_BITS-1:0] step_wdata,
    hss_point_if.sink                 point_in,
    hss_sample_if.source              sample_out
);
    logic [STEP_BITS-1:0] step_size_reg;
    hss_cmd_t  cmd;
    hss_stat_t stat;
    logic      run_end;

    // hold the step register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            step_size_reg <= STEP_RESET;
        else if (step_we)
            step_size_reg <= step_wdata;
    end

    hss_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (point_in.valid),
        .in_final (point_in.final_point),
        .in_ready (point_in.ready),
        .stat     (stat),
        .cmd      (cmd),
        .run_end  (run_end)
    );

    hss_datapath #(
        .COORD_BITS  (COORD_BITS),
        .MAX_SAMPLES (MAX_SAMPLES)
    ) u_dp (
        .clk           (clk),
        .rst_n         (rst_n),
        .step_size     (step_size_reg),
        .in_x          (point_in.point_x),
        .in_y          (point_in.point_y),
        .in_z          (point_in.point_z),
        .cmd           (cmd),
        .run_end_in    (run_end),
        .out_ready     (sample_out.ready),
        .stat          (stat),
        .out_valid     (sample_out.valid),
        .out_x         (sample_out.out_x),
        .out_y         (sample_out.out_y),
        .out_z         (sample_out.out_z),
        .out_run_end   (sample_out.run_end),
        .out_curve_end (sample_out.curve_end)
    );

    // the endpoint always closes its run
    `HSS_ASSERT_SAME(a_curve_run, clk, rst_n,
        sample_out.valid && sample_out.curve_end, sample_out.run_end,
        "curve end without run end")
    // no new point while the previous one is still being worked
    `HSS_ASSERT_SAME(a_one_item, clk, rst_n,
        point_in.ready, !cmd.sample_go && !cmd.seg_start,
        "point accepted during segment work")
    // an endpoint load raises output valid
    `HSS_ASSERT_NEXT(a_end_valid, clk, rst_n,
        cmd.emit_end, sample_out.valid && sample_out.curve_end,
        "endpoint not presented")
endmodule
`default_nettype wire
